/* rtl/crc64_stream_and_prng_assert.svh */
// assertion macros used by the crc64 stream and prng rtl
// expects clk and arst_n in the scope of every use
`ifndef CRC64_STREAM_AND_PRNG_ASSERT_SVH
`define CRC64_STREAM_AND_PRNG_ASSERT_SVH

// property holds at every clock edge outside reset
`define CRC64SP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// antecedent in one cycle implies consequent in the same cycle
`define CRC64SP_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent in one cycle implies consequent in the next cycle
`define CRC64SP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/crc64sp_pkg.sv */
// types, register codes and crc-64 folding functions for the crc64 stream and prng
// no dependencies; used by crc64sp_engine and crc64_stream_and_prng
package crc64sp_pkg;

	localparam logic [63:0] CRC_POLY    = 64'hC96C5795D7870F42;
	localparam logic [63:0] START_RESET = 64'hFFFFFFFFFFFFFFFF;
	localparam logic [63:0] SEED_RESET  = 64'h0;

	localparam int CFG_INDEX_W = 8;
	localparam logic [CFG_INDEX_W-1:0] REG_START_VALUE = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SEED        = 8'd1;

	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_DRAW = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
		logic       first;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic        result_kind;
		logic [63:0] value;
	} out_item_t;

	typedef struct packed {
		logic        start_we;
		logic        seed_we;
		logic [63:0] data;
	} cfg_wr_t;

	typedef logic [7:0][63:0]  col8_t;
	typedef logic [63:0][63:0] col64_t;

	// one-bit-at-a-time reflected crc shift, elaboration only
	function automatic logic [63:0] shift_bits(input logic [63:0] x, input int n);
		logic [63:0] c;
		c = x;
		for (int k = 0; k < n; k++) begin
			c = (c >> 1) ^ (c[0] ? CRC_POLY : 64'h0);
		end
		return c;
	endfunction

	function automatic col8_t make_col8();
		col8_t t;
		for (int i = 0; i < 8; i++) begin
			t[i] = shift_bits(64'h1 << i, 8);
		end
		return t;
	endfunction

	function automatic col64_t make_col64();
		col64_t t;
		for (int i = 0; i < 64; i++) begin
			t[i] = shift_bits(64'h1 << i, 64);
		end
		return t;
	endfunction

	localparam col8_t  FOLD8_COL  = make_col8();
	localparam col64_t FOLD64_COL = make_col64();

	// eight shift steps as one xor network
	function automatic logic [63:0] fold8(input logic [63:0] x);
		logic [63:0] acc;
		acc = x >> 8;
		for (int i = 0; i < 8; i++) begin
			acc = acc ^ (x[i] ? FOLD8_COL[i] : 64'h0);
		end
		return acc;
	endfunction

	// sixty-four shift steps as one xor network
	function automatic logic [63:0] fold64(input logic [63:0] x);
		logic [63:0] acc;
		acc = 64'h0;
		for (int i = 0; i < 64; i++) begin
			acc = acc ^ (x[i] ? FOLD64_COL[i] : 64'h0);
		end
		return acc;
	endfunction

endpackage

/* rtl/crc64sp_engine.sv */
// state registers and single-pass crc-64 datapath of the crc64 stream and prng
// depends on crc64sp_pkg
module crc64sp_engine
	import crc64sp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        take,
	input  in_item_t    item,
	input  cfg_wr_t     cfg,
	output logic        emit,
	output out_item_t   result
);

	logic [63:0] start_q;
	logic [63:0] running_q;
	logic [63:0] random_q;
	logic [63:0] sum_base;
	logic [63:0] sum_next;
	logic [63:0] draw_next;

	assign sum_base  = item.first ? start_q : running_q;
	assign sum_next  = fold8(sum_base ^ {56'h0, item.data_byte});
	assign draw_next = fold64(start_q ^ random_q);

	assign emit               = (item.kind == KIND_DRAW) || item.last;
	assign result.result_kind = item.kind;
	assign result.value       = (item.kind == KIND_DRAW) ? draw_next : sum_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q   <= START_RESET;
			running_q <= START_RESET;
			random_q  <= SEED_RESET;
		end else begin
			if (take && item.kind == KIND_DATA) begin
				running_q <= sum_next;
			end
			if (take && item.kind == KIND_DRAW) begin
				random_q <= draw_next;
			end
			if (cfg.start_we) begin
				start_q <= cfg.data;
			end
			if (cfg.seed_we) begin
				random_q <= cfg.data;
			end
		end
	end

endmodule

/* rtl/crc64_stream_and_prng.sv */
// crc64 stream and prng: input register, engine and result register
// depends on crc64sp_pkg, crc64sp_engine and crc64_stream_and_prng_assert.svh
//
// usage
// in channel: in_valid/in_stall carry one in_item_t per transaction; kind 0 folds
//   data_byte into the running reflected crc-64 (first restarts it from start_value,
//   last returns it), kind 1 draws a new random number from the random state
// out channel: out_valid/out_stall carry one out_item_t per returned value; data
//   bytes without last return nothing
// cfg channel: cfg_valid/cfg_ready write start_value (index 0) or seed (index 1);
//   cfg_ready is always high, other indexes are dropped, write only while idle
// path: an accepted item waits in the input register, then its result is registered in res_q
// throughput: one item per cycle while no returning item waits on out_stall; the byte fold and
//   the 64-bit draw are each one xor network between the input register and the result register
// stall: a held result keeps its value; the input register still drains items
//   that return nothing, and in_stall rises once a returning item must wait
// reset: start_value and running checksum all ones, random state zero, both
//   channels empty
`include "crc64_stream_and_prng_assert.svh"

module crc64_stream_and_prng
	import crc64sp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  in_item_t               in_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output out_item_t              out_data,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [63:0]            cfg_data
);

	logic      valid_s1;
	in_item_t  item_s1;
	logic      res_valid_q;
	out_item_t res_q;
	logic      out_free;
	logic      adv;
	logic      emit;
	out_item_t result;
	cfg_wr_t   cfg;

	assign cfg_ready    = 1'b1;
	assign cfg.start_we = cfg_valid && cfg_ready && (cfg_index == REG_START_VALUE);
	assign cfg.seed_we  = cfg_valid && cfg_ready && (cfg_index == REG_SEED);
	assign cfg.data     = cfg_data;

	assign out_free = !res_valid_q || !out_stall;
	assign adv      = valid_s1 && (!emit || out_free);
	assign in_stall = valid_s1 && !adv;

	assign out_valid = res_valid_q;
	assign out_data  = res_q;

	crc64sp_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.emit   (emit),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv && emit) begin
				res_valid_q <= 1'b1;
			end else if (!out_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
		if (adv && emit) begin
			res_q <= result;
		end
	end

	`CRC64SP_ASSERT_IMPL(a_stall_needs_item, in_stall, valid_s1, "stall without held item")
	`CRC64SP_ASSERT_IMPL(a_no_overwrite, valid_s1 && emit && res_valid_q && out_stall, in_stall && !adv, "held result would be overwritten")
	`CRC64SP_ASSERT_NEXT(a_draw_returns, adv && item_s1.kind == KIND_DRAW, res_valid_q && res_q.result_kind == KIND_DRAW, "draw did not return a random number")
	`CRC64SP_ASSERT_NEXT(a_silent_keeps_result, adv && !emit && res_valid_q && out_stall, res_valid_q && $stable(res_q), "item without result disturbed held result")

endmodule

/* tb/crc64_stream_and_prng_tb.sv */
// self-checking testbench for crc64_stream_and_prng: byte-wise reflected crc-64 and draws
// uses crc64sp_pkg for item types, register indexes and the polynomial; needs only the rtl
// directed items first, then phases of random packets, draws and noise under random stalls
module crc64_stream_and_prng_tb
	import crc64sp_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int DRAIN_CYCLES   = 10;
	localparam int PHASE_ITEMS    = 100;
	localparam int NUM_PHASES     = 6;
	localparam int HOLD_CYCLES    = 150;
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LO = REG_SEED + 1'b1;
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_HI = '1;

	class crc64_result_board;
		logic [63:0] start_value;
		logic [63:0] random_state;
		logic [63:0] running_sum;
		out_item_t   expected_values[$];
		int          errors;

		function new();
			start_value  = START_RESET;
			random_state = SEED_RESET;
			running_sum  = START_RESET;
			errors       = 0;
		endfunction

		function logic [63:0] crc_fold_byte(logic [63:0] crc, logic [7:0] b);
			logic [63:0] c;
			c = crc ^ {56'h0, b};
			for (int k = 0; k < 8; k++) begin
				c = (c >> 1) ^ (c[0] ? CRC_POLY : 64'h0);
			end
			return c;
		endfunction

		function void note_write(logic [CFG_INDEX_W-1:0] idx, logic [63:0] data);
			if (idx == REG_START_VALUE) begin
				start_value = data;
			end else if (idx == REG_SEED) begin
				random_state = data;
			end
		endfunction

		function void note_item(in_item_t it);
			out_item_t   res;
			logic [63:0] crc;
			if (it.kind == KIND_DATA) begin
				if (it.first) begin
					running_sum = start_value;
				end
				running_sum = crc_fold_byte(running_sum, it.data_byte);
				if (it.last) begin
					res.result_kind = KIND_DATA;
					res.value       = running_sum;
					expected_values.push_back(res);
				end
			end else begin
				crc = start_value;
				for (int i = 0; i < 8; i++) begin
					crc = crc_fold_byte(crc, random_state[8*i +: 8]);
				end
				random_state    = crc;
				res.result_kind = KIND_DRAW;
				res.value       = crc;
				expected_values.push_back(res);
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (expected_values.size() == 0) begin
				$error("unexpected result: result_kind %0d value %h", got.result_kind, got.value);
				errors++;
				return;
			end
			want = expected_values.pop_front();
			if (got.result_kind !== want.result_kind) begin
				$error("result_kind expected %0d actual %0d", want.result_kind, got.result_kind);
				errors++;
			end
			if (got.value !== want.value) begin
				$error("value expected %h actual %h", want.value, got.value);
				errors++;
			end
		endfunction

		function int pending();
			return expected_values.size();
		endfunction
	endclass

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   in_valid  = 1'b0;
	logic                   in_stall;
	in_item_t               in_data   = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	out_item_t              out_data;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [63:0]            cfg_data  = '0;

	crc64_result_board board = new();
	int  burst_left = 0;
	int  idle_cycles = 0;
	bit  hold_req = 1'b0;

	crc64_stream_and_prng u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic in_item_t make_item(logic kind, logic [7:0] b, logic f, logic l);
		in_item_t it;
		it.kind      = kind;
		it.data_byte = b;
		it.first     = f;
		it.last      = l;
		return it;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic send_item(in_item_t it);
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (in_stall);
		board.note_item(it);
	endtask

	task automatic sender_gap(int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic offer(in_item_t it);
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0) begin
				sender_gap($urandom_range(1, 6));
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		send_item(it);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [63:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		board.note_write(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// wait for outstanding results, then let items without results drain
	task automatic settle();
		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic send_packet(int len);
		for (int i = 0; i < len; i++) begin
			offer(make_item(KIND_DATA, 8'($urandom_range(0, 255)), i == 0, i == len - 1));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			board.check_result(out_data);
		end
	end

	// receiver stall pattern, with one forced long hold once random traffic starts
	initial begin
		int  n;
		int  mode;
		bit  hold_done;
		hold_done = 1'b0;
		forever begin
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				mode = 9;
				n = HOLD_CYCLES;
			end else begin
				mode = $urandom_range(0, 19);
				n = (mode == 19) ? $urandom_range(20, 60) : $urandom_range(1, 30);
				mode = (mode == 19) ? 9 : mode % 9;
			end
			for (int c = 0; c < n; c++) begin
				if (mode <= 3) begin
					out_stall <= 1'b0;
				end else if (mode <= 6) begin
					out_stall <= 1'($urandom_range(0, 1));
				end else if (mode <= 8) begin
					out_stall <= (c % 3 == 2);
				end else begin
					out_stall <= 1'b1;
				end
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
			    (cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("crc64_stream_and_prng regression: fail");
				$finish;
			end
		end
	end

	initial begin
		int          count;
		int          r;
		logic [63:0] sv;
		logic [63:0] seed_val;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset state: no first uses all ones, first and last, multi-byte, extension
		offer(make_item(KIND_DATA, 8'h00, 1'b0, 1'b1));
		offer(make_item(KIND_DATA, 8'hFF, 1'b1, 1'b1));
		offer(make_item(KIND_DATA, 8'hA5, 1'b1, 1'b0));
		offer(make_item(KIND_DATA, 8'h5A, 1'b0, 1'b0));
		offer(make_item(KIND_DATA, 8'h3C, 1'b0, 1'b1));
		offer(make_item(KIND_DATA, 8'h81, 1'b0, 1'b1));
		// draws leave the running checksum alone and ignore the data fields
		offer(make_item(KIND_DRAW, 8'h00, 1'b0, 1'b0));
		offer(make_item(KIND_DRAW, 8'hFF, 1'b1, 1'b1));
		offer(make_item(KIND_DATA, 8'h00, 1'b0, 1'b0));
		offer(make_item(KIND_DATA, 8'h7E, 1'b0, 1'b1));
		settle();

		write_reg(REG_START_VALUE, 64'h0);
		write_reg(REG_SEED, '1);
		write_reg(REG_UNUSED_LO, 64'h0);
		write_reg(REG_UNUSED_HI, '1);
		// new start value only applies at the next first mark
		offer(make_item(KIND_DATA, 8'h55, 1'b0, 1'b1));
		offer(make_item(KIND_DATA, 8'h00, 1'b1, 1'b1));
		offer(make_item(KIND_DRAW, 8'h00, 1'b0, 1'b0));
		offer(make_item(KIND_DRAW, 8'h00, 1'b0, 1'b0));
		settle();

		write_reg(REG_START_VALUE, '1);
		write_reg(REG_SEED, 64'h0);
		offer(make_item(KIND_DATA, 8'hFF, 1'b1, 1'b0));
		offer(make_item(KIND_DATA, 8'h01, 1'b0, 1'b1));
		offer(make_item(KIND_DRAW, 8'h00, 1'b0, 1'b0));
		settle();

		hold_req = 1'b1;
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: begin sv = '1; seed_val = rand64(); end
				1: begin sv = 64'h0; seed_val = 64'h0; end
				2: begin sv = rand64(); seed_val = '1; end
				default: begin sv = rand64(); seed_val = rand64(); end
			endcase
			write_reg(REG_START_VALUE, sv);
			if ($urandom_range(0, 1) != 0 || p < 3) begin
				write_reg(REG_SEED, seed_val);
			end
			if (p == 3) begin
				write_reg(CFG_INDEX_W'($urandom_range(2, 255)), rand64());
			end
			count = 0;
			while (count < PHASE_ITEMS) begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					r = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16)
					                                 : $urandom_range(1, 8);
					send_packet(r);
					count += r;
				end else if (r < 85) begin
					offer(make_item(KIND_DRAW, 8'($urandom_range(0, 255)),
					                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
					count++;
				end else begin
					offer(in_item_t'(11'($urandom_range(0, 2047))));
					count++;
				end
			end
			settle();
		end

		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("crc64_stream_and_prng regression: pass");
		end else begin
			$display("crc64_stream_and_prng regression: fail");
		end
		$finish;
	end

endmodule
